@@ rtl/core/swm_pkg.sv @@
// shared constants and types for the sliding window maximum block
// no dependencies; compile first
package swm_pkg;

  localparam int WINDOW_MAX_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  // window size register
  localparam int             WS_BITS  = 7;
  localparam logic [WS_BITS-1:0] WS_RESET = 7'd3;

  // apb-style configuration port
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;

  // register index, taken from paddr above the byte offset
  localparam logic [0:0] REG_WINDOW_SIZE = 1'b0;

  // broadcast control for the row of queue cells
  typedef struct packed {
    logic load;   // an item updates the row this cycle
    logic start;  // the item begins a new sequence
    logic drop;   // front entry leaves, row moves one cell toward the front
  } cell_ctl_t;

endpackage

@@ rtl/core/swm_in_if.sv @@
// input channel of the sliding window maximum block: valid/ready plus sample fields
// depends on nothing
interface swm_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   start_req;

  modport source (output valid, output sample, output start_req, input ready);
  modport sink   (input valid, input sample, input start_req, output ready);
endinterface

@@ rtl/core/swm_out_if.sv @@
// result channel of the sliding window maximum block: valid/ready plus window_max
// depends on nothing
interface swm_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] window_max;

  modport source (output valid, output window_max, input ready);
  modport sink   (input valid, input window_max, output ready);
endinterface

@@ rtl/core/sliding_window_max.sv @@
// top level of the sliding window maximum block: cell row, control, apb register
// depends on swm_pkg, swm_in_if, swm_out_if, swm_cell
//
// Streams signed samples and, from the window_size-th sample of the current
// sequence on, returns the maximum of the last window_size samples for each
// such sample. Candidates live in a row of WINDOW_MAX cells that form a
// monotonic queue, front cell first: every cell compares its value with the new
// sample in parallel, dominated candidates drop out at the back, the sample is
// written into the first free cell, and when the front candidate ages out the
// whole row moves one cell toward the front, each cell taking its neighbor's
// entry. The sustained rate is one item per clock while results are taken. An
// accepted item stays pending until the front cell is settled and, if it gives
// a result, the output register is free, which then takes the result. While a
// result waits to be taken the input takes one more item and then holds off
// until the output register is free again, unless that item gives no result.
// After a write that makes the window smaller, the next item stays pending
// while each further stale candidate is shifted out, since the row only moves
// by one cell per cycle. start_req on an item discards all candidates and
// restarts the sample count. A window size of zero acts as one and sizes above
// WINDOW_MAX act as WINDOW_MAX. The window size register sits at byte address
// 0 of the apb-style port and resets to 3; pready is always high.
module sliding_window_max #(
  parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  swm_in_if.sink                             in_ch,
  swm_out_if.source                          out_ch,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [swm_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [swm_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic [swm_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                               pready
);
  import swm_pkg::*;

  localparam int N  = WINDOW_MAX;
  localparam int AW = $clog2(WINDOW_MAX + 1);
  localparam int CW = (AW > WS_BITS) ? AW : WS_BITS;
  localparam logic [CW-1:0] WMAX_C = CW'(WINDOW_MAX);
  localparam logic [AW-1:0] WMAX_A = AW'(WINDOW_MAX);

  // configuration register
  logic [WS_BITS-1:0] ws_r, ws_nxt;
  logic               reg_sel;
  logic               cfg_wr;
  logic [CW-1:0]      ws_ext;
  logic [AW-1:0]      w_eff;

  // control state
  logic          pending_r, pending_nxt;
  logic          emit_r, emit_nxt;
  logic [AW-1:0] seen_r, seen_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [SAMPLE_BITS-1:0] out_data_r, out_data_nxt;

  logic      in_fire;
  logic      out_free;
  logic      exp_cur;
  logic      exp_post;
  logic      drain;
  logic      resolve;
  cell_ctl_t ctl;
  logic [AW-1:0] seen_base;

  // cell row wiring, index N is the empty slot past the last cell
  logic [N:0]                  surv_chain;
  logic [N:0]                  p_valid;
  logic [N:0][SAMPLE_BITS-1:0] p_value;
  logic [N:0][AW-1:0]          p_age;
  logic [N:0]                  c_valid;
  logic [N:0][SAMPLE_BITS-1:0] c_value;
  logic [N:0][AW-1:0]          c_age;

  // apb register access
  assign pready  = 1'b1;
  assign reg_sel = (paddr[CFG_ADDR_BITS-1:2] == REG_WINDOW_SIZE);
  assign cfg_wr  = psel && penable && pwrite && reg_sel;
  assign ws_nxt  = cfg_wr ? pwdata[WS_BITS-1:0] : ws_r;
  assign prdata  = reg_sel ? {{(CFG_DATA_BITS-WS_BITS){1'b0}}, ws_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r <= WS_RESET;
    end else begin
      ws_r <= ws_nxt;
    end
  end

  // effective window: zero acts as one, clamp to the row length
  assign ws_ext = CW'(ws_r);
  always_comb begin
    priority if (ws_r == '0) begin
      w_eff = AW'(1);
    end else if (ws_ext > WMAX_C) begin
      w_eff = WMAX_A;
    end else begin
      w_eff = ws_ext[AW-1:0];
    end
  end

  // front cell expiry, before and after the update an item makes
  assign exp_cur  = c_valid[0] && (c_age[0] >= w_eff);
  assign exp_post = p_valid[0] && (p_age[0] >= w_eff);

  // an accepted item is pending until the front cell is settled and its
  // result, if any, has a place in the output register
  assign out_free = !out_valid_r || out_ch.ready;
  assign resolve  = pending_r && !exp_cur && (!emit_r || out_free);
  assign drain    = pending_r && exp_cur;

  assign in_ch.ready = !pending_r || resolve;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign ctl.load  = in_fire;
  assign ctl.start = in_ch.start_req;
  assign ctl.drop  = in_fire ? exp_post : drain;

  // samples seen in this sequence, saturating at the window
  always_comb begin
    seen_base = in_ch.start_req ? '0 : seen_r;
    if (seen_base > w_eff) begin
      seen_base = w_eff;
    end
    if (seen_base < w_eff) begin
      seen_base = seen_base + AW'(1);
    end
  end

  always_comb begin
    pending_nxt = pending_r;
    emit_nxt    = emit_r;
    seen_nxt    = seen_r;
    if (in_fire) begin
      pending_nxt = 1'b1;
      seen_nxt    = seen_base;
      emit_nxt    = (seen_base == w_eff);
    end else if (resolve) begin
      pending_nxt = 1'b0;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (resolve && emit_r) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = c_value[0];
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.window_max = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r   <= 1'b0;
      emit_r      <= 1'b0;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pending_r   <= pending_nxt;
      emit_r      <= emit_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // row of queue cells, cell 0 holds the current maximum
  // the slot past the last cell offers the new key when the whole row
  // survives, so it still lands in the last cell when the row moves up
  assign surv_chain[0] = 1'b1;
  assign p_valid[N]    = surv_chain[N];
  assign p_value[N]    = in_ch.sample;
  assign p_age[N]      = '0;
  assign c_valid[N]    = 1'b0;
  assign c_value[N]    = '0;
  assign c_age[N]      = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    swm_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .AGE_BITS    (AW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .key       ($signed(in_ch.sample)),
      .left_surv (surv_chain[i]),
      .surv      (surv_chain[i+1]),
      .r_p_valid (p_valid[i+1]),
      .r_p_value (p_value[i+1]),
      .r_p_age   (p_age[i+1]),
      .r_c_valid (c_valid[i+1]),
      .r_c_value (c_value[i+1]),
      .r_c_age   (c_age[i+1]),
      .p_valid   (p_valid[i]),
      .p_value   (p_value[i]),
      .p_age     (p_age[i]),
      .c_valid   (c_valid[i]),
      .c_value   (c_value[i]),
      .c_age     (c_age[i])
    );
  end

`ifndef ASSERT_OFF
  // no item enters while stale candidates are still being shifted out
  a_no_fire_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    drain |-> !in_fire)
    else $error("item accepted during front drain");

  // the newest sample always lands in the row, so the front is not empty after an item
  a_front_valid: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> c_valid[0])
    else $error("front cell empty after an item");

  // a candidate in cell 1 implies a candidate in the front cell
  a_row_packed: assert property (@(posedge clk) disable iff (!rst_n)
    c_valid[1] |-> c_valid[0])
    else $error("gap at the front of the candidate row");

  // a resolved item with a result fills the output register
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (resolve && emit_r) |=> (out_valid_r && !pending_r) || in_fire || pending_r)
    else $error("result not loaded on resolve");

  // a result is only taken from a front entry inside the window
  a_front_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (resolve && emit_r) |=> (out_data_r == $past(c_value[0])))
    else $error("result does not match front candidate");
`endif

endmodule

@@ rtl/core/swm_cell.sv @@
// one cell of the monotonic candidate queue: value, age and valid flag
// depends on swm_pkg
module swm_cell #(
  parameter int SAMPLE_BITS = 16,
  parameter int AGE_BITS    = 7
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  swm_pkg::cell_ctl_t            ctl,
  input  logic signed [SAMPLE_BITS-1:0] key,
  input  logic                          left_surv,
  output logic                          surv,
  // right neighbor, post-update and current views
  input  logic                          r_p_valid,
  input  logic        [SAMPLE_BITS-1:0] r_p_value,
  input  logic        [AGE_BITS-1:0]    r_p_age,
  input  logic                          r_c_valid,
  input  logic        [SAMPLE_BITS-1:0] r_c_value,
  input  logic        [AGE_BITS-1:0]    r_c_age,
  // this cell, post-update and current views
  output logic                          p_valid,
  output logic        [SAMPLE_BITS-1:0] p_value,
  output logic        [AGE_BITS-1:0]    p_age,
  output logic                          c_valid,
  output logic        [SAMPLE_BITS-1:0] c_value,
  output logic        [AGE_BITS-1:0]    c_age
);
  import swm_pkg::*;

  logic                   valid_r, valid_nxt;
  logic [SAMPLE_BITS-1:0] value_r, value_nxt;
  logic [AGE_BITS-1:0]    age_r, age_nxt;

  // entry survives if newer key is strictly smaller
  assign surv = valid_r && !ctl.start && !($signed(value_r) <= key);

  always_comb begin
    if (surv) begin
      p_valid = 1'b1;
      p_value = value_r;
      p_age   = age_r + AGE_BITS'(1);
    end else if (left_surv) begin
      // first free slot behind the survivors takes the new key
      p_valid = 1'b1;
      p_value = key;
      p_age   = '0;
    end else begin
      p_valid = 1'b0;
      p_value = value_r;
      p_age   = age_r;
    end
  end

  assign c_valid = valid_r;
  assign c_value = value_r;
  assign c_age   = age_r;

  always_comb begin
    priority if (ctl.load && ctl.drop) begin
      valid_nxt = r_p_valid;
      value_nxt = r_p_value;
      age_nxt   = r_p_age;
    end else if (ctl.load) begin
      valid_nxt = p_valid;
      value_nxt = p_value;
      age_nxt   = p_age;
    end else if (ctl.drop) begin
      valid_nxt = r_c_valid;
      value_nxt = r_c_value;
      age_nxt   = r_c_age;
    end else begin
      valid_nxt = valid_r;
      value_nxt = value_r;
      age_nxt   = age_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    age_r   <= age_nxt;
  end

endmodule

@@ bench/window_max_check_pkg.sv @@
`timescale 1ns / 1ps
// scoreboard for the sliding window maximum bench: candidate-queue predictor and result check
// depends on swm_pkg
package window_max_check_pkg;

  typedef logic signed [swm_pkg::SAMPLE_BITS_DEF-1:0] sample_t;

  class window_max_checker;

    typedef struct {
      sample_t     value;
      int unsigned age;
    } cand_t;

    logic [swm_pkg::WS_BITS-1:0] window_reg = swm_pkg::WS_RESET;
    cand_t       cands[$];     // falling values front to back, ages falling too
    int unsigned seen;         // samples of the current sequence, saturating
    sample_t     expected_max[$];
    int unsigned errors;

    task set_window(logic [swm_pkg::WS_BITS-1:0] ws);
      window_reg = ws;
    endtask

    function int unsigned pending();
      return expected_max.size();
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("mismatch: %s", what);
    endtask

    // advance the predictor by one accepted item
    task note_sample(sample_t s, bit st);
      int unsigned w;
      cand_t       c;
      w = window_reg;
      if (w == 0) w = 1;
      if (w > swm_pkg::WINDOW_MAX_DEF) w = swm_pkg::WINDOW_MAX_DEF;
      if (st) begin
        cands.delete();
        seen = 0;
      end
      foreach (cands[i]) cands[i].age++;
      while (cands.size() > 0 && cands[0].age >= w) void'(cands.pop_front());
      while (cands.size() > 0 && cands[$].value <= s) void'(cands.pop_back());
      if (cands.size() < swm_pkg::WINDOW_MAX_DEF) begin
        c.value = s;
        c.age   = 0;
        cands = {cands, c};
      end
      if (seen > w) seen = w;
      if (seen < w) seen++;
      if (seen >= w) expected_max = {expected_max, cands[0].value};
    endtask

    task check_max(sample_t got);
      sample_t want;
      if (expected_max.size() == 0) begin
        report_mismatch($sformatf("window_max %0d with nothing expected", got));
      end else begin
        want = expected_max.pop_front();
        if (got !== want) report_mismatch($sformatf("window_max %0d, expected %0d", got, want));
      end
    endtask

  endclass

endpackage

@@ bench/sliding_window_max_tb.sv @@
`timescale 1ns / 1ps
// top of the sliding window maximum bench: drives samples and window writes, checks every result
// depends on swm_pkg, swm_in_if, swm_out_if, window_max_check_pkg and the block itself
module sliding_window_max_tb;
  import swm_pkg::*;
  import window_max_check_pkg::*;

  localparam int SAMPLE_BITS    = SAMPLE_BITS_DEF;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int HOLD_CYCLES    = 300;  // long receiver hold-off, fills the block
  localparam int SETTLE_CYCLES  = 8;    // settle wait, the result register is loaded behind its item
  localparam int NUM_PHASES     = 12;

  // window settings of the random part, extremes and shrink/grow steps included
  localparam logic [WS_BITS-1:0] PHASE_WINDOW [NUM_PHASES] = '{
    7'd127, 7'd1, 7'd5, 7'd0, 7'd64, 7'd2, 7'd65, 7'd12, 7'd3, 7'd33, 7'd9, 7'd4
  };

  typedef enum int {
    STYLE_FULL,
    STYLE_NARROW,   // few distinct values, lots of ties
    STYLE_FALLING,  // deep candidate queue
    STYLE_RISING,   // queue collapses every item
    STYLE_EDGES
  } sample_style_t;

  logic clk = 1'b0;
  logic rst_n;

  // apb-style configuration port
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [CFG_ADDR_BITS-1:0] paddr;
  logic [CFG_DATA_BITS-1:0] pwdata;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic                     pready;

  swm_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) in_bus ();
  swm_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) out_bus ();

  window_max_checker sb;

  int unsigned cycle_count;
  bit          quiet;       // no idling on either side while set
  int unsigned hold_req;    // bumped by the sender side to ask for a long hold-off
  int unsigned hold_seen;
  int unsigned hold_left;
  int unsigned stall_left;
  int          ramp_level;

  sliding_window_max #(
    .WINDOW_MAX (WINDOW_MAX_DEF),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // mostly no gap, some short ones, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int next_sample(sample_style_t style);
    case (style)
      STYLE_FULL:   return int'($urandom_range(0, 65535)) - 32768;
      STYLE_NARROW: return int'($urandom_range(0, 8)) - 4;
      STYLE_FALLING: begin
        // steps of zero keep equal neighbors in the run
        ramp_level -= int'($urandom_range(0, 300));
        if (ramp_level < -32768) ramp_level = 32767;
        return ramp_level;
      end
      STYLE_RISING: begin
        ramp_level += int'($urandom_range(0, 300));
        if (ramp_level > 32767) ramp_level = -32768;
        return ramp_level;
      end
      default: begin
        case ($urandom_range(0, 5))
          0:       return -32768;
          1:       return 32767;
          2:       return -32767;
          3:       return 32766;
          4:       return 0;
          default: return -1;
        endcase
      end
    endcase
  endfunction

  // offer one item, hold it until taken, then maybe idle
  task automatic offer(input int value, input bit st);
    sample_t     s;
    int unsigned gap;
    s = sample_t'(value);
    in_bus.valid     <= 1'b1;
    in_bus.sample    <= s;
    in_bus.start_req <= st;
    do @(posedge clk); while (!in_bus.ready);
    sb.note_sample(s, st);
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering and wait until every expected item has come back
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    // items that give no result may still be inside the block
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // setup cycle then access cycle, register takes the value at the access edge
  task automatic write_window(input logic [WS_BITS-1:0] ws);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_BITS'({REG_WINDOW_SIZE, 2'b00});
    pwdata  <= CFG_DATA_BITS'(ws);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_window(ws);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // receiver: random stalls, long hold-off on request, checks every accepted result
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_bus.valid && out_bus.ready) sb.check_max(sample_t'(out_bus.window_max));
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= rst_n;
        if (!quiet) stall_left = pick_gap();
      end
    end
  end

  // run limit, far above the slowest passing run
  initial begin
    cycle_count = 0;
    while (cycle_count < TIMEOUT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    sample_style_t style;
    bit            st;
    int unsigned   eff;
    int unsigned   n;

    sb = new;
    rst_n            <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    in_bus.valid     <= 1'b0;
    in_bus.sample    <= '0;
    in_bus.start_req <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset window of three: extremes, ties, expiry of the front
    offer(32767, 1'b1);
    offer(-32768, 1'b0);
    offer(-32768, 1'b0);
    offer(-32768, 1'b0);
    offer(5, 1'b0);
    offer(5, 1'b0);
    offer(5, 1'b0);
    offer(-1, 1'b0);
    offer(0, 1'b0);
    offer(32767, 1'b0);
    offer(-32767, 1'b0);
    // new sequence in the middle of a stream
    offer(-32768, 1'b1);
    offer(1, 1'b0);
    offer(2, 1'b0);
    // window grows mid-sequence, falling run builds a deep queue
    wait_idle();
    write_window(7'd6);
    offer(100, 1'b0);
    offer(90, 1'b0);
    offer(80, 1'b0);
    offer(70, 1'b0);
    // window shrinks mid-sequence, several stale candidates at the front
    wait_idle();
    write_window(7'd2);
    offer(60, 1'b0);
    offer(65, 1'b0);
    offer(-5, 1'b0);
    // window of zero acts as one
    wait_idle();
    write_window(7'd0);
    offer(-9, 1'b0);
    offer(32767, 1'b0);
    offer(-32768, 1'b0);

    // random part: one window setting per phase, sequences with random content
    style      = STYLE_FULL;
    ramp_level = 0;
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      write_window(PHASE_WINDOW[p]);
      quiet = (p % 4 == 3);
      eff = PHASE_WINDOW[p];
      if (eff == 0) eff = 1;
      if (eff > WINDOW_MAX_DEF) eff = WINDOW_MAX_DEF;
      n = eff + 30;
      for (int k = 0; k < int'(n); k++) begin
        st = (k == 0 && $urandom_range(0, 1) == 1) || $urandom_range(0, 39) == 0;
        if (st || $urandom_range(0, 15) == 0) style = sample_style_t'($urandom_range(0, 4));
        // receiver holds off while items keep coming, so the block backs up
        if ((p == 1 && k == 5) || (p == 4 && k == 20)) hold_req++;
        // sender stops until every result is back, sequence then carries on
        if (p == 7 && k == 20) wait_idle();
        offer(next_sample(style), st);
      end
    end

    quiet = 1'b0;
    wait_idle();
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/swm_pkg.sv
rtl/core/swm_in_if.sv
rtl/core/swm_out_if.sv
rtl/core/swm_cell.sv
rtl/core/sliding_window_max.sv
bench/window_max_check_pkg.sv
bench/sliding_window_max_tb.sv
